// ----- hdl/sha256_stream_hasher_top_macros.svh -----
// Assertion helpers shared by the hasher RTL.
// Both forms sample on the rising edge of clock and are disabled while reset is high.
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH

// Same-cycle implication.
`define SHS_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SHS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/shs_pkg.sv -----
package shs_pkg;

   typedef logic [31:0] word_type;

   // Input kinds carried on req_tuser.
   localparam logic CMD_PUSH   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // Byte positions within a 64-byte block.
   localparam logic [5:0] POS_LAST = 6'd63;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Control from the sequencer to the message schedule.
   typedef struct packed {
      logic byte_en;   // shift one message byte into the block
      logic round_en;  // advance the schedule by one word
   } sched_ctl_type;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   // Round constants.
   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      unique case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      endcase
      round_k = k;
   endfunction

endpackage

// ----- hdl/shs_sched.sv -----
// Message block and schedule window. Bytes shift in at the low end while a
// block fills; during rounds the register shifts one word per cycle and the
// next schedule word enters at the low end. The oldest word sits at the top.
module shs_sched
   import shs_pkg::*;
(
   input  logic          clock,
   input  sched_ctl_type ctl,
   input  logic [7:0]    byte_in,
   output word_type      w_cur
);

   logic [511:0] blk_ff;
   logic [511:0] blk_in;
   word_type     w_new;

   // Word i of the window is blk_ff[511-32*i -: 32].
   assign w_cur = blk_ff[511:480];

   // Next schedule word from the sixteen-word window.
   assign w_new = small_sigma1(blk_ff[63:32]) + blk_ff[223:192]
                + small_sigma0(blk_ff[479:448]) + blk_ff[511:480];

   always_comb begin
      blk_in = blk_ff;
      if (ctl.byte_en) begin
         blk_in = {blk_ff[503:0], byte_in};
      end else if (ctl.round_en) begin
         blk_in = {blk_ff[479:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

endmodule

// ----- hdl/sha256_stream_hasher_top.sv -----
// SHA-256 over a byte stream. Each req transaction with tuser low appends the
// byte in tdata; one with tuser high finishes the message, and the block then
// returns the eight digest words as eight rsp transactions, word 0 first,
// tlast on the eighth, after which it starts a fresh message. Bytes are taken
// one per cycle while idle, but the byte that completes a 64-byte block holds
// req_tready low while one shared round unit runs the 64 rounds, one per
// cycle, and a final state folds the result into the hash. A finish inserts
// the padding and length one byte per cycle, compresses one or two blocks,
// then presents the digest words; no new request is taken until the last word
// has been taken.
`include "sha256_stream_hasher_top_macros.svh"

module sha256_stream_hasher_top
   import shs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
   output logic        rsp_tlast    // last_word
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FINAL,
      ST_OUT
   } state_type;

   state_type     state_ff, state_in;
   logic [60:0]   cnt_ff, cnt_in;
   logic [63:0]   len_ff, len_in;
   logic          fin_ff, fin_in;
   logic          final_blk_ff, final_blk_in;
   logic          pad_first_ff, pad_first_in;
   logic [5:0]    rnd_ff, rnd_in;
   logic [2:0]    idx_ff, idx_in;
   word_type      hash_ff [8];
   word_type      hash_in [8];
   word_type      wv_ff [8];
   word_type      wv_in [8];

   sched_ctl_type sched_ctl;
   logic [7:0]    blk_byte;
   word_type      w_cur;
   word_type      t1;
   word_type      t2;
   logic [5:0]    pos;
   logic          req_acc;
   logic          rsp_acc;

   shs_sched u_sched (
      .clock   (clock),
      .ctl     (sched_ctl),
      .byte_in (blk_byte),
      .w_cur   (w_cur)
   );

   assign pos     = cnt_ff[5:0];
   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Handshake and result outputs.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'd0, idx_ff, hash_ff[idx_ff]};
   assign rsp_tlast  = (idx_ff == 3'd7);

   // Round function on the working variables.
   assign t1 = wv_ff[7] + big_sigma1(wv_ff[4])
             + ((wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]))
             + round_k(rnd_ff) + w_cur;
   assign t2 = big_sigma0(wv_ff[0])
             + ((wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]));

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      fin_in       = fin_ff;
      final_blk_in = final_blk_ff;
      pad_first_in = pad_first_ff;
      rnd_in       = rnd_ff;
      idx_in       = idx_ff;
      hash_in      = hash_ff;
      wv_in        = wv_ff;
      sched_ctl    = '0;
      blk_byte     = req_tdata;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_tuser == CMD_PUSH)) begin
               sched_ctl.byte_en = 1'b1;
               cnt_in = cnt_ff + 61'd1;
               if (pos == POS_LAST) begin
                  state_in = ST_ROUND;
                  rnd_in   = '0;
                  wv_in    = hash_ff;
               end
            end else if (req_acc) begin
               len_in       = {cnt_ff, 3'b000};
               fin_in       = 1'b1;
               pad_first_in = 1'b1;
               final_blk_in = (pos < LEN_POS);
               state_in     = ST_PAD;
            end
         end

         ST_PAD: begin
            // Marker byte first, then zeros, then the length on the final block.
            sched_ctl.byte_en = 1'b1;
            pad_first_in      = 1'b0;
            cnt_in            = cnt_ff + 61'd1;
            if (pad_first_ff) begin
               blk_byte = PAD_MARK;
            end else if (final_blk_ff && (pos >= LEN_POS)) begin
               blk_byte = len_ff[63:56];
               len_in   = {len_ff[55:0], 8'd0};
            end else begin
               blk_byte = 8'd0;
            end
            if (pos == POS_LAST) begin
               state_in = ST_ROUND;
               rnd_in   = '0;
               wv_in    = hash_ff;
            end
         end

         ST_ROUND: begin
            sched_ctl.round_en = 1'b1;
            wv_in[0] = t1 + t2;
            wv_in[1] = wv_ff[0];
            wv_in[2] = wv_ff[1];
            wv_in[3] = wv_ff[2];
            wv_in[4] = wv_ff[3] + t1;
            wv_in[5] = wv_ff[4];
            wv_in[6] = wv_ff[5];
            wv_in[7] = wv_ff[6];
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == POS_LAST) begin
               state_in = ST_FINAL;
            end
         end

         ST_FINAL: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + wv_ff[i];
            end
            priority if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (final_blk_ff) begin
               state_in = ST_OUT;
               idx_in   = '0;
            end else begin
               final_blk_in = 1'b1;
               state_in     = ST_PAD;
            end
         end

         ST_OUT: begin
            if (rsp_acc) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  hash_in  = INIT_HASH;
                  cnt_in   = '0;
                  fin_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         fin_ff       <= 1'b0;
         final_blk_ff <= 1'b0;
         pad_first_ff <= 1'b0;
         rnd_ff       <= '0;
         idx_ff       <= '0;
         hash_ff      <= INIT_HASH;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fin_ff       <= fin_in;
         final_blk_ff <= final_blk_in;
         pad_first_ff <= pad_first_in;
         rnd_ff       <= rnd_in;
         idx_ff       <= idx_in;
         hash_ff      <= hash_in;
      end
      len_ff <= len_in;
      wv_ff  <= wv_in;
   end

   // The request and result sides are never open at the same time.
   `SHS_ASSERT_NOW(a_no_overlap, rsp_tvalid, !req_tready, "request taken while digest pending")
   // The last round is always followed by the hash update.
   `SHS_ASSERT_NEXT(a_round_end, (state_ff == ST_ROUND) && (rnd_ff == POS_LAST), state_ff == ST_FINAL, "round count overrun")
   // A byte that fills the block starts compression at round zero.
   `SHS_ASSERT_NEXT(a_blk_full, req_acc && (req_tuser == CMD_PUSH) && (pos == POS_LAST), (state_ff == ST_ROUND) && (rnd_ff == 6'd0), "full block not compressed")
   // Digest words are shown only after the padded final block.
   `SHS_ASSERT_NOW(a_out_final, state_ff == ST_OUT, fin_ff && final_blk_ff, "digest before final block")
   // The last digest word leaves the block ready for a new message.
   `SHS_ASSERT_NEXT(a_restart, rsp_acc && rsp_tlast, req_tready && (cnt_ff == 61'd0), "no restart after digest")

endmodule
